// File: hdl/bsp_pkg.sv
// Package: shared constants, types and control structs of the beacon scan parser.
`default_nettype none
package bsp_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int POSITION_BITS_DEF = 12;
	localparam int SSID_BYTES        = 32;
	localparam int SSID_AW           = $clog2(SSID_BYTES);

	localparam int MIN_FRAME   = 38;
	localparam int WALK_START  = 36;
	localparam int BSSID_FIRST = 16;
	localparam int BSSID_END   = 22;

	localparam logic [7:0] SUB_MASK       = 8'hF0;
	localparam logic [7:0] SUB_BEACON     = 8'h80;
	localparam logic [7:0] SUB_PROBE_RESP = 8'h50;
	localparam logic [7:0] EID_SSID       = 8'd0;
	localparam logic [7:0] EID_DS         = 8'd3;
	localparam logic [7:0] EID_RSN        = 8'd48;

	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_IGNORED   = 3'd3,
		ST_CLEARED   = 3'd4,
		ST_READ      = 3'd5,
		ST_BAD_INDEX = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_EMIT_IGN,
		S_SRCH,
		S_SRCH_CMP,
		S_EMIT_DUP,
		S_DECIDE,
		S_EMIT_FULL,
		S_COPY,
		S_STORE,
		S_EMIT_CLR,
		S_RD_CHK,
		S_EMIT_BAD,
		S_RD_EMIT,
		S_RD_BYTE
	} state_t;

	typedef struct packed {
		logic     [47:0] bssid;
		logic     [7:0]  channel;
		logic     [7:0]  rssi;
		logic     [5:0]  ssid_cnt;
		logic            rsn;
	} entry_t;

	typedef struct packed {
		logic    accept;
		logic    byte_en;
		logic    frame_clr;
		logic    tbl_clr;
		logic    srch_init;
		logic    srch_rd;
		logic    srch_next;
		logic    k_clr;
		logic    k_inc;
		logic    copy_we;
		logic    entry_we;
		logic    entry_rd;
		logic    ssid_rd;
		logic    out_load;
		status_t sel;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  is_last;
		logic  frame_ok;
		logic  srch_done;
		logic  match;
		logic  full;
		logic  copy_done;
		logic  idx_bad;
		logic  len_zero;
		logic  k_last;
		logic  out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/bsp_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module bsp_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/bsp_dp.sv
// Datapath: frame byte parser, SSID banks, scan table memories and output register.
`default_nettype none
module bsp_dp import bsp_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [23:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tlast,
	output logic      [87:0] m_tdata,
	output logic      [2:0]  m_tuser,
	output logic             m_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire cmd_t        cmd,
	output sts_t             sts
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = IW + 1;
	localparam int PB = POSITION_BITS;
	localparam int EW = $bits(entry_t);

	logic [7:0] in_byte;
	logic [7:0] in_rssi;
	logic [3:0] in_idx;
	assign in_byte = s_tdata[7:0];
	assign in_rssi = s_tdata[15:8];
	assign in_idx  = s_tdata[19:16];

	// parser state
	logic [PB-1:0] pos_q, pos_n;
	logic [7:0]    fc_lo_q, fc_lo_n;
	logic [47:0]   bssid_q, bssid_n;
	phase_t        phase_q, phase_n;
	logic [7:0]    eid_q, eid_n;
	logic [7:0]    erem_q, erem_n;
	logic [7:0]    etot_q, etot_n;
	logic          stopped_q, stopped_n;
	logic          bank_q, bank_n;
	logic [5:0]    flen_q, flen_n;
	logic [7:0]    fchan_q, fchan_n;
	logic          frsn_q, frsn_n;
	logic [7:0]    first_q, first_n;
	logic          pend_we;
	logic [7:0]    didx;
	logic          done;

	logic [7:0] bank0 [SSID_BYTES];
	logic [7:0] bank1 [SSID_BYTES];

	logic [CW-1:0] valid_q;
	logic [CW-1:0] srch_q;
	logic [5:0]    k_q;
	logic [7:0]    rssi_q;
	logic [3:0]    idx_q;

	logic          out_valid_q;
	logic [87:0]   out_data_q;
	logic [2:0]    out_user_q;
	logic          out_last_q;

	entry_t        ent_rd;
	logic [EW-1:0] ent_rdata;
	logic [7:0]    ssid_rdata;
	entry_t        ent_wr;
	logic [7:0]    found_byte;

	always_comb begin
		pos_n     = pos_q;
		fc_lo_n   = fc_lo_q;
		bssid_n   = bssid_q;
		phase_n   = phase_q;
		eid_n     = eid_q;
		erem_n    = erem_q;
		etot_n    = etot_q;
		stopped_n = stopped_q;
		bank_n    = bank_q;
		flen_n    = flen_q;
		fchan_n   = fchan_q;
		frsn_n    = frsn_q;
		first_n   = first_q;
		pend_we   = 1'b0;
		done      = 1'b0;
		didx      = etot_q - erem_q;
		if (cmd.byte_en) begin
			if (pos_q == '0) begin
				fc_lo_n = in_byte;
			end
			if (pos_q == PB'(1)) begin
				if ((fc_lo_q & SUB_MASK) != SUB_BEACON &&
				    (fc_lo_q & SUB_MASK) != SUB_PROBE_RESP) begin
					stopped_n = 1'b1;
				end
			end
			if (pos_q >= PB'(BSSID_FIRST) && pos_q < PB'(BSSID_END)) begin
				bssid_n = {bssid_q[39:0], in_byte};
			end
			if (pos_q >= PB'(WALK_START) && !stopped_q) begin
				case (phase_q)
					PH_ID: begin
						eid_n   = in_byte;
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						etot_n = in_byte;
						erem_n = in_byte;
						if (in_byte == 8'd0) begin
							done = 1'b1;
						end else begin
							phase_n = PH_DATA;
						end
					end
					default: begin
						if (didx < 8'(SSID_BYTES)) begin
							pend_we = 1'b1;
						end
						if (didx == 8'd0) begin
							first_n = in_byte;
						end
						erem_n = erem_q - 8'd1;
						if (erem_q == 8'd1) begin
							done = 1'b1;
						end
					end
				endcase
				if (done) begin
					phase_n = PH_ID;
					if (eid_q == EID_SSID && etot_n <= 8'(SSID_BYTES)) begin
						bank_n = ~bank_q;
						flen_n = etot_n[5:0];
					end else if (eid_q == EID_DS && etot_n != 8'd0) begin
						fchan_n = first_n;
					end else if (eid_q == EID_RSN) begin
						frsn_n = 1'b1;
					end
				end
			end
			if (pos_q != '1) begin
				pos_n = pos_q + PB'(1);
			end
		end
		if (cmd.frame_clr) begin
			pos_n     = '0;
			fc_lo_n   = '0;
			bssid_n   = '0;
			phase_n   = PH_ID;
			eid_n     = '0;
			erem_n    = '0;
			etot_n    = '0;
			stopped_n = 1'b0;
			flen_n    = '0;
			fchan_n   = '0;
			frsn_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fc_lo_q     <= '0;
			bssid_q     <= '0;
			phase_q     <= PH_ID;
			eid_q       <= '0;
			erem_q      <= '0;
			etot_q      <= '0;
			stopped_q   <= 1'b0;
			bank_q      <= 1'b0;
			flen_q      <= '0;
			fchan_q     <= '0;
			frsn_q      <= 1'b0;
			valid_q     <= '0;
			srch_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pos_q     <= pos_n;
			fc_lo_q   <= fc_lo_n;
			bssid_q   <= bssid_n;
			phase_q   <= phase_n;
			eid_q     <= eid_n;
			erem_q    <= erem_n;
			etot_q    <= etot_n;
			stopped_q <= stopped_n;
			bank_q    <= bank_n;
			flen_q    <= flen_n;
			fchan_q   <= fchan_n;
			frsn_q    <= frsn_n;
			if (cmd.tbl_clr) begin
				valid_q <= '0;
			end else if (cmd.entry_we) begin
				valid_q <= valid_q + CW'(1);
			end
			if (cmd.srch_init) begin
				srch_q <= '0;
			end else if (cmd.srch_next) begin
				srch_q <= srch_q + CW'(1);
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + 6'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		first_q <= first_n;
		if (pend_we) begin
			if (bank_q) begin
				bank0[didx[SSID_AW-1:0]] <= in_byte;
			end else begin
				bank1[didx[SSID_AW-1:0]] <= in_byte;
			end
		end
		if (cmd.accept) begin
			rssi_q <= in_rssi;
			idx_q  <= in_idx;
		end
	end

	assign found_byte = bank_q ? bank1[k_q[SSID_AW-1:0]] : bank0[k_q[SSID_AW-1:0]];

	assign ent_wr.bssid    = bssid_q;
	assign ent_wr.channel  = fchan_q;
	assign ent_wr.rssi     = rssi_q;
	assign ent_wr.ssid_cnt = flen_q;
	assign ent_wr.rsn      = frsn_q;

	bsp_ram #(.WIDTH(EW), .ADDR_W(IW)) u_entry_ram (
		.clk   (clk),
		.we    (cmd.entry_we),
		.waddr (valid_q[IW-1:0]),
		.wdata (ent_wr),
		.re    (cmd.srch_rd | cmd.entry_rd),
		.raddr (cmd.srch_rd ? srch_q[IW-1:0] : IW'(idx_q)),
		.rdata (ent_rdata)
	);
	assign ent_rd = entry_t'(ent_rdata);

	bsp_ram #(.WIDTH(8), .ADDR_W(IW + SSID_AW)) u_ssid_ram (
		.clk   (clk),
		.we    (cmd.copy_we),
		.waddr ({valid_q[IW-1:0], k_q[SSID_AW-1:0]}),
		.wdata (found_byte),
		.re    (cmd.ssid_rd),
		.raddr ({IW'(idx_q), k_q[SSID_AW-1:0]}),
		.rdata (ssid_rdata)
	);

	assign sts.mode      = mode_t'(s_tuser);
	assign sts.is_last   = s_tlast;
	assign sts.frame_ok  = (pos_q >= PB'(MIN_FRAME)) && !stopped_q;
	assign sts.srch_done = (srch_q == valid_q);
	assign sts.match     = (ent_rd.bssid == bssid_q);
	assign sts.full      = (valid_q >= CW'(TABLE_ENTRIES));
	assign sts.copy_done = (k_q == flen_q);
	assign sts.idx_bad   = (16'(idx_q) >= 16'(valid_q));
	assign sts.len_zero  = (ent_rd.ssid_cnt == 6'd0);
	assign sts.k_last    = ((k_q + 6'd1) == ent_rd.ssid_cnt);
	assign sts.out_free  = !out_valid_q || m_tready;

	// result field build
	logic [3:0]  o_slot;
	logic [4:0]  o_count;
	logic [47:0] o_bssid;
	logic [7:0]  o_chan;
	logic        o_rsn;
	logic [7:0]  o_rssi;
	logic [5:0]  o_len;
	logic [7:0]  o_byte;
	logic        o_last;

	always_comb begin
		o_slot  = '0;
		o_count = 5'(valid_q);
		o_bssid = '0;
		o_chan  = '0;
		o_rsn   = 1'b0;
		o_rssi  = '0;
		o_len   = '0;
		o_byte  = '0;
		o_last  = 1'b1;
		case (cmd.sel)
			ST_STORED, ST_DUPLICATE, ST_FULL: begin
				o_bssid = bssid_q;
				o_chan  = fchan_q;
				o_rsn   = frsn_q;
				o_rssi  = rssi_q;
				o_len   = flen_q;
				if (cmd.sel == ST_STORED) begin
					o_slot  = 4'(valid_q);
					o_count = 5'(valid_q + CW'(1));
				end else if (cmd.sel == ST_DUPLICATE) begin
					o_slot = 4'(srch_q);
				end
			end
			ST_CLEARED: begin
				o_count = '0;
			end
			ST_READ: begin
				o_slot  = idx_q;
				o_bssid = ent_rd.bssid;
				o_chan  = ent_rd.channel;
				o_rsn   = ent_rd.rsn;
				o_rssi  = ent_rd.rssi;
				o_len   = ent_rd.ssid_cnt;
				o_byte  = sts.len_zero ? 8'd0 : ssid_rdata;
				o_last  = sts.len_zero || sts.k_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {o_byte, o_len, o_rssi, o_rsn, o_chan, o_bssid, o_count, o_slot};
			out_user_q <= cmd.sel;
			out_last_q <= o_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q <= CW'(TABLE_ENTRIES))
		else $error("entry count above table size");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.entry_we |-> !sts.full)
		else $error("store into full table");
	a_walk_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.byte_en |-> !cmd.frame_clr)
		else $error("byte taken during frame clear");
`endif
endmodule
`default_nettype wire

// File: hdl/bsp_ctrl.sv
// Controller: sequences frame end lookup, table store and entry read.
`default_nettype none
module bsp_ctrl import bsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (sts.mode)
						MODE_BYTE:  state_n = sts.is_last ? S_CHECK : S_IDLE;
						MODE_CLEAR: state_n = S_EMIT_CLR;
						MODE_READ:  state_n = S_RD_CHK;
						default:    state_n = S_IDLE;
					endcase
				end
			end
			S_CHECK:    state_n = sts.frame_ok ? S_SRCH : S_EMIT_IGN;
			S_SRCH:     state_n = sts.srch_done ? S_DECIDE : S_SRCH_CMP;
			S_SRCH_CMP: state_n = sts.match ? S_EMIT_DUP : S_SRCH;
			S_DECIDE:   state_n = sts.full ? S_EMIT_FULL : S_COPY;
			S_COPY:     state_n = sts.copy_done ? S_STORE : S_COPY;
			S_RD_CHK:   state_n = sts.idx_bad ? S_EMIT_BAD : S_RD_EMIT;
			S_RD_BYTE:  state_n = S_RD_EMIT;
			S_RD_EMIT: begin
				if (sts.out_free) begin
					state_n = (sts.len_zero || sts.k_last) ? S_IDLE : S_RD_BYTE;
				end
			end
			S_EMIT_IGN, S_EMIT_DUP, S_EMIT_FULL, S_STORE, S_EMIT_CLR, S_EMIT_BAD: begin
				if (sts.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = ST_IGNORED;
		s_tready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.accept    = s_tvalid;
				cmd.byte_en   = s_tvalid && (sts.mode == MODE_BYTE);
				cmd.tbl_clr   = s_tvalid && (sts.mode == MODE_CLEAR);
				cmd.srch_init = 1'b1;
				cmd.k_clr     = 1'b1;
			end
			S_CHECK: begin
				cmd.srch_init = 1'b1;
			end
			S_SRCH: begin
				cmd.srch_rd = !sts.srch_done;
				cmd.k_clr   = 1'b1;
			end
			S_SRCH_CMP: begin
				cmd.srch_next = !sts.match;
			end
			S_COPY: begin
				cmd.copy_we = !sts.copy_done;
				cmd.k_inc   = !sts.copy_done;
			end
			S_RD_CHK: begin
				cmd.entry_rd = !sts.idx_bad;
				cmd.ssid_rd  = !sts.idx_bad;
				cmd.k_clr    = 1'b1;
			end
			S_RD_BYTE: begin
				cmd.ssid_rd = 1'b1;
			end
			S_RD_EMIT: begin
				cmd.sel      = ST_READ;
				cmd.out_load = sts.out_free;
				cmd.k_inc    = sts.out_free && !(sts.len_zero || sts.k_last);
			end
			S_EMIT_IGN: begin
				cmd.sel       = ST_IGNORED;
				cmd.out_load  = sts.out_free;
				cmd.frame_clr = sts.out_free;
			end
			S_EMIT_DUP: begin
				cmd.sel       = ST_DUPLICATE;
				cmd.out_load  = sts.out_free;
				cmd.frame_clr = sts.out_free;
			end
			S_EMIT_FULL: begin
				cmd.sel       = ST_FULL;
				cmd.out_load  = sts.out_free;
				cmd.frame_clr = sts.out_free;
			end
			S_STORE: begin
				cmd.sel       = ST_STORED;
				cmd.out_load  = sts.out_free;
				cmd.entry_we  = sts.out_free;
				cmd.frame_clr = sts.out_free;
			end
			S_EMIT_CLR: begin
				cmd.sel      = ST_CLEARED;
				cmd.out_load = sts.out_free;
			end
			S_EMIT_BAD: begin
				cmd.sel      = ST_BAD_INDEX;
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.out_load)
		else $error("result loaded while taking items");
	a_store_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.entry_we |=> state_q == S_IDLE)
		else $error("store not followed by idle");
	a_last_check: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.byte_en && sts.is_last) |=> state_q == S_CHECK)
		else $error("frame end missed");
`endif
endmodule
`default_nettype wire

// File: hdl/beacon_scan_parser_table_core.sv
// Top level: beacon and probe response parser with scan table.
// Frame bytes: one item per cycle while the controller is idle, no result unless last.
// Frame end: a check state, a read and a compare state per valid entry searched, a decide state,
// an SSID copy step per stored byte and a store state; output stalls hold the result state.
// Entry read: each SSID byte is fetched via the registered SSID memory, then emitted; an empty SSID gives one result.
// Reset clears control and parser state and the entry count; memories are not cleared.
`default_nettype none
module beacon_scan_parser_table_core import bsp_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // frame_byte, rssi, entry_index, pad
	input  wire logic [1:0]  s_tuser,  // mode
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [87:0] m_tdata,  // slot, entry_count, bssid, channel, rsn_present,
	                                   // entry_rssi, ssid_length, ssid_byte
	output logic      [2:0]  m_tuser,  // status
	output logic             m_tlast
);
	cmd_t cmd;
	sts_t sts;

	bsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsp_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule
`default_nettype wire

// File: bench/beacon_scan_parser_table_core_chk.sv
// Checker: predicts scan parser results from accepted items and compares them on the output.
`default_nettype none
module beacon_scan_parser_table_core_chk import bsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [87:0] m_tdata,
	input  wire logic [2:0]  m_tuser,
	input  wire logic        m_tlast,
	output int               errors,
	output int               pending,
	output int               n_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NENT = TABLE_ENTRIES_DEF;
	localparam int POS_MAX = 2 ** POSITION_BITS_DEF - 1;

	// laid out as {m_tuser, m_tdata, m_tlast}
	typedef struct packed {
		status_t     status;
		logic [7:0]  sbyte;
		logic [5:0]  sslen;
		logic [7:0]  rssi;
		logic        rsn;
		logic [7:0]  channel;
		logic [47:0] bssid;
		logic [4:0]  count;
		logic [3:0]  slot;
		logic        last;
	} scan_result_t;

	scan_result_t scan_results_q[$];

	logic [47:0] t_bssid [NENT];
	logic [7:0]  t_ssid  [NENT][SSID_BYTES];
	logic [5:0]  t_len   [NENT];
	logic [7:0]  t_chan  [NENT];
	logic [7:0]  t_rssi  [NENT];
	logic        t_rsn   [NENT];
	int          n_valid;
	int          pos;
	logic [15:0] fc;
	logic [47:0] f_bssid;
	phase_t      ph;
	logic [7:0]  e_id;
	int          e_rem, e_tot;
	logic        stopped;
	logic [7:0]  pend [SSID_BYTES];
	logic [7:0]  fnd  [SSID_BYTES];
	int          f_len;
	logic [7:0]  f_chan;
	logic        f_rsn;

	assign pending = scan_results_q.size();

	function automatic scan_result_t mk(status_t st, int slot, int cnt, logic [47:0] b,
		logic [7:0] ch, logic r, logic [7:0] rs, int sl, logic [7:0] sb, logic lst);
		scan_result_t x;
		x.status = st; x.slot = 4'(slot); x.count = 5'(cnt); x.bssid = b; x.channel = ch;
		x.rsn = r; x.rssi = rs; x.sslen = 6'(sl); x.sbyte = sb; x.last = lst;
		return x;
	endfunction

	function automatic void reset_frame();
		pos = 0; fc = 0; f_bssid = 0; ph = PH_ID; e_id = 0; e_rem = 0; e_tot = 0;
		stopped = 0; f_len = 0; f_chan = 0; f_rsn = 0;
	endfunction

	function automatic void close_element();
		if (e_id == EID_SSID && e_tot <= SSID_BYTES) begin
			fnd = pend;
			f_len = e_tot;
		end else if (e_id == EID_DS && e_tot >= 1) begin
			f_chan = pend[0];
		end else if (e_id == EID_RSN) begin
			f_rsn = 1;
		end
		ph = PH_ID;
	endfunction

	function automatic void frame_done(logic [7:0] rs);
		int i;
		if (pos < MIN_FRAME || stopped) begin
			scan_results_q.push_back(mk(ST_IGNORED, 0, n_valid, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		for (i = 0; i < n_valid; i++)
			if (t_bssid[i] == f_bssid) begin
				scan_results_q.push_back(mk(ST_DUPLICATE, i, n_valid, f_bssid, f_chan, f_rsn,
					rs, f_len, 0, 1));
				return;
			end
		if (n_valid >= NENT) begin
			scan_results_q.push_back(mk(ST_FULL, 0, n_valid, f_bssid, f_chan, f_rsn, rs,
				f_len, 0, 1));
			return;
		end
		i = n_valid;
		for (int k = 0; k < SSID_BYTES; k++) t_ssid[i][k] = k < f_len ? fnd[k] : 8'd0;
		t_len[i] = 6'(f_len); t_bssid[i] = f_bssid; t_chan[i] = f_chan;
		t_rssi[i] = rs; t_rsn[i] = f_rsn;
		n_valid++;
		scan_results_q.push_back(mk(ST_STORED, i, n_valid, f_bssid, f_chan, f_rsn, rs,
			f_len, 0, 1));
	endfunction

	function automatic void predict_item(logic [1:0] md, logic [7:0] b, logic lst,
		logic [7:0] rs, logic [3:0] ix);
		int len;
		case (md)
		MODE_BYTE: begin
			if (pos == 0) begin
				fc = 16'(b);
			end else if (pos == 1) begin
				fc = fc | (16'(b) << 8);
				if ((fc[7:0] & SUB_MASK) != SUB_BEACON && (fc[7:0] & SUB_MASK) != SUB_PROBE_RESP)
					stopped = 1;
			end else if (pos >= BSSID_FIRST && pos < BSSID_END) begin
				f_bssid = {f_bssid[39:0], b};
			end
			if (pos >= WALK_START && !stopped) begin
				if (ph == PH_ID) begin
					e_id = b; ph = PH_LEN;
				end else if (ph == PH_LEN) begin
					e_tot = int'(b); e_rem = int'(b);
					if (b == 0) close_element();
					else ph = PH_DATA;
				end else begin
					if (e_tot - e_rem < SSID_BYTES) pend[e_tot - e_rem] = b;
					e_rem--;
					if (e_rem == 0) close_element();
				end
			end
			if (pos < POS_MAX) pos++;
			if (lst) begin
				frame_done(rs);
				reset_frame();
			end
		end
		MODE_CLEAR: begin
			n_valid = 0;
			scan_results_q.push_back(mk(ST_CLEARED, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		end
		MODE_READ: begin
			if (int'(ix) >= n_valid) begin
				scan_results_q.push_back(mk(ST_BAD_INDEX, 0, n_valid, 0, 0, 0, 0, 0, 0, 1));
			end else begin
				len = int'(t_len[ix]);
				if (len == 0)
					scan_results_q.push_back(mk(ST_READ, ix, n_valid, t_bssid[ix], t_chan[ix],
						t_rsn[ix], t_rssi[ix], 0, 0, 1));
				for (int k = 0; k < len; k++)
					scan_results_q.push_back(mk(ST_READ, ix, n_valid, t_bssid[ix], t_chan[ix],
						t_rsn[ix], t_rssi[ix], len, t_ssid[ix][k], k + 1 == len));
			end
		end
		default: ;
		endcase
	endfunction

	initial begin
		n_valid = 0;
		reset_frame();
		errors = 0;
		n_results = 0;
	end

	always @(posedge clk) begin
		scan_result_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata, m_tlast};
				n_results++;
				if (scan_results_q.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					errors++;
				end else begin
					want = scan_results_q.pop_front();
					if (got != want) begin
						$display("%0t: mismatch expected %p", $realtime, want);
						$display("%0t:          actual   %p", $realtime, got);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata[7:0], s_tlast, s_tdata[15:8], s_tdata[19:16]);
		end
	end
endmodule
`default_nettype wire

// File: bench/beacon_scan_parser_table_core_tb.sv
// Testbench top: drives frames, clears and entry reads into the scan parser and gives the verdict.
`default_nettype none
module beacon_scan_parser_table_core_tb import bsp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0, arst_n = 0;
	logic        s_tvalid = 0, s_tlast = 0, m_tready = 0;
	logic [23:0] s_tdata = 0;
	logic [1:0]  s_tuser = MODE_BYTE;
	wire         s_tready, m_tvalid, m_tlast;
	wire  [87:0] m_tdata;
	wire  [2:0]  m_tuser;
	int          errors, pending, n_results;
	int          items = 0, frames = 0;
	longint      cycles = 0;
	logic [7:0]  frame_buf[$];

	beacon_scan_parser_table_core dut (.*);

	beacon_scan_parser_table_core_chk chk (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if ($urandom_range(0, 99) < 8) m_tready <= 0;
		else if ($urandom_range(0, 99) < 40 || !m_tready) m_tready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send(mode_t md, logic [7:0] b, logic lst, logic [7:0] rs, logic [3:0] ix);
		int g;
		g = gap_len();
		repeat (g) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= md;
		s_tdata <= {4'd0, ix, rs, b};
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items++;
	endtask

	task automatic idle_off();
		s_tvalid <= 0;
	endtask

	// header with given subtype and bssid, then elements appended by caller
	task automatic build_hdr(logic [7:0] fc0, logic [47:0] b);
		frame_buf = {};
		frame_buf.push_back(fc0);
		frame_buf.push_back(8'($urandom));
		for (int i = 2; i < 36; i++)
			frame_buf.push_back((i >= 16 && i < 22) ? b[8 * (21 - i) +: 8] : 8'($urandom));
	endtask

	task automatic add_elem(logic [7:0] id, int len);
		frame_buf.push_back(id);
		frame_buf.push_back(8'(len));
		repeat (len) frame_buf.push_back(8'($urandom));
	endtask

	task automatic send_frame_rs(logic [7:0] rs);
		for (int i = 0; i < frame_buf.size(); i++)
			send(MODE_BYTE, frame_buf[i], i == frame_buf.size() - 1,
				i == frame_buf.size() - 1 ? rs : 8'($urandom), 4'($urandom));
		frames++;
	endtask

	function automatic logic [7:0] pick_fc();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return {4'h8, 4'($urandom)};
		if (r < 8) return {4'h5, 4'($urandom)};
		return 8'($urandom);
	endfunction

	function automatic logic [47:0] pick_bssid();
		if ($urandom_range(0, 2) == 0) return {44'h0, 4'($urandom)};
		return {$urandom, 16'($urandom)};
	endfunction

	task automatic random_frame();
		int ne, k;
		build_hdr(pick_fc(), pick_bssid());
		ne = $urandom_range(0, 4);
		repeat (ne) begin
			k = $urandom_range(0, 9);
			case (k)
			0, 1, 2: add_elem(EID_SSID, $urandom_range(0, 3) == 0 ? $urandom_range(0, 40)
				: $urandom_range(0, 12));
			3, 4: add_elem(EID_DS, $urandom_range(0, 2));
			5: add_elem(EID_RSN, $urandom_range(0, 4));
			default: add_elem(8'($urandom), $urandom_range(0, 6));
			endcase
		end
		if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) frame_buf.pop_back();
		else repeat (4) frame_buf.push_back(8'($urandom));
		if ($urandom_range(0, 9) == 0)
			while (frame_buf.size() > $urandom_range(1, 37)) frame_buf.pop_back();
		send_frame_rs(8'($urandom));
	endtask

	initial begin
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part
		send(MODE_READ, 8'h00, 0, 8'h00, 4'd0);
		build_hdr(8'h80, 48'hFFFF_FFFF_FFFF);
		add_elem(EID_SSID, 32); add_elem(EID_DS, 1); add_elem(EID_RSN, 2);
		send_frame_rs(8'h7F);
		build_hdr(8'h50, 48'h0);
		add_elem(EID_SSID, 33); add_elem(EID_DS, 0);
		send_frame_rs(8'h80);
		build_hdr(8'h40, 48'h1); add_elem(EID_SSID, 4);
		send_frame_rs(8'h00);
		build_hdr(8'h80, 48'hFFFF_FFFF_FFFF); add_elem(EID_SSID, 3);
		send_frame_rs(8'hFF);
		build_hdr(8'h80, 48'h2); add_elem(EID_SSID, 10); frame_buf.pop_back();
		send_frame_rs(8'h01);
		send(MODE_BYTE, 8'hFF, 1, 8'hFF, 4'hF);
		send(MODE_NONE, 8'hFF, 0, 8'hFF, 4'hF);
		send(MODE_READ, 8'hFF, 1, 8'hFF, 4'd0);
		send(MODE_READ, 8'h00, 0, 8'h00, 4'd1);
		send(MODE_READ, 8'h00, 0, 8'h00, 4'd2);
		send(MODE_READ, 8'h00, 0, 8'h00, 4'd15);
		send(MODE_CLEAR, 8'hAA, 1, 8'h55, 4'hA);

		// random part
		while (items < 310) begin
			n = $urandom_range(0, 19);
			if (n < 12 && items < 300) random_frame();
			else if (n < 13)
				send(MODE_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 4'($urandom));
			else if (n < 14)
				send(MODE_NONE, 8'($urandom), 1'($urandom), 8'($urandom), 4'($urandom));
			else if (n < 15)
				send(MODE_BYTE, 8'($urandom), 1'b1, 8'($urandom), 4'($urandom));
			else
				send(MODE_READ, 8'($urandom), 1'($urandom), 8'($urandom), 4'($urandom));
		end
		idle_off();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d items in %0d frames plus clears and reads; %0d results checked.",
			items, frames, n_results);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
